/* rtl/core/fat32_file_sector_sequencer_unit_assert.svh */
// ---------------------------------------------------------------------------
// FAT32 sector sequencer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef FAT32_FILE_SECTOR_SEQUENCER_UNIT_ASSERT_SVH
`define FAT32_FILE_SECTOR_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define FSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fss check failed: same-cycle rule");

// next-cycle implication, masked during reset
`define FSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fss check failed: next-cycle rule");

`endif

/* rtl/core/fss_pkg.sv */
// ---------------------------------------------------------------------------
// FAT32 sector sequencer package
// Widths, codes, result record and helpers shared by the sequencer files.
// ---------------------------------------------------------------------------
package fss_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam int CLUSTER_W = 32;
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 32;
   localparam int POS_W     = 33;
   localparam int INDEX_W   = 7;
   localparam int CS_W      = 8;
   localparam int CS_MAX    = 128;
   localparam int ENTRY_W   = 28;
   localparam int OFFSET_W  = 9;
   localparam int VALID_W   = 10;
   localparam int KIND_W    = 3;
   localparam int OP_W      = 2;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_FAT_START  = 2'd0;
   localparam logic [1:0] REG_DATA_START = 2'd1;
   localparam logic [1:0] REG_CLUS_SECT  = 2'd2;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_OPEN   = 2'd0,
      OP_READ   = 2'd1,
      OP_REPLY  = 2'd2,
      OP_REWIND = 2'd3
   } fss_op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA      = 3'd0,
      KIND_FAT       = 3'd1,
      KIND_EOF       = 3'd2,
      KIND_ACK       = 3'd3,
      KIND_BUSY      = 3'd4,
      KIND_CHAIN_END = 3'd5
   } fss_kind_type;

   typedef struct packed {
      fss_kind_type          kind;
      logic [ADDR_W-1:0]     sector_addr;
      logic [OFFSET_W-1:0]   entry_offset;
      logic [VALID_W-1:0]    valid_bytes;
      logic                  last;
   } fss_rsp_type;

   // clusters 0 and 1 are reserved; treat them as the first data cluster
   function automatic logic [CLUSTER_W-1:0] map_cluster(input logic [CLUSTER_W-1:0] c);
      logic [CLUSTER_W-1:0] r;
      r = (c < CLUSTER_W'(2)) ? CLUSTER_W'(2) : c;
      return r;
   endfunction

   // sectors per cluster, clamped to 1..128
   function automatic logic [CS_W-1:0] eff_sectors(input logic [CS_W-1:0] cs);
      logic [CS_W-1:0] r;
      if (cs == '0) begin
         r = CS_W'(1);
      end else if (cs > CS_W'(CS_MAX)) begin
         r = CS_W'(CS_MAX);
      end else begin
         r = cs;
      end
      return r;
   endfunction

endpackage

/* rtl/core/fss_if.sv */
// ---------------------------------------------------------------------------
// FAT32 sector sequencer channels
// Valid/ready request and response channels with their payload fields.
// ---------------------------------------------------------------------------
interface fss_req_if;
   logic                           valid;
   logic                           ready;
   logic [fss_pkg::OP_W-1:0]       op;
   logic [fss_pkg::CLUSTER_W-1:0]  cluster_value;
   logic [fss_pkg::SIZE_W-1:0]     file_bytes;

   modport source (output valid, output op, output cluster_value, output file_bytes,
                   input ready);
   modport sink   (input valid, input op, input cluster_value, input file_bytes,
                   output ready);
endinterface

interface fss_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fss_pkg::KIND_W-1:0]     kind;
   logic [fss_pkg::ADDR_W-1:0]     sector_addr;
   logic [fss_pkg::OFFSET_W-1:0]   entry_offset;
   logic [fss_pkg::VALID_W-1:0]    valid_bytes;
   logic                           last;

   modport source (output valid, output kind, output sector_addr, output entry_offset,
                   output valid_bytes, output last, input ready);
   modport sink   (input valid, input kind, input sector_addr, input entry_offset,
                   input valid_bytes, input last, output ready);
endinterface

/* rtl/core/fat32_file_sector_sequencer_unit.sv */
// Results: a request's results are registered into the result queue on its transfer
//   and offered in order, a FAT fetch right behind its data sector.
// Throughput: one request per cycle while at most two results are queued (4-entry
//   result queue); a read that ends a cluster puts two results in the queue, so sustained rate is set by rsp drain.
// Reset (synchronous, active high): queue empty, registers to defaults, file state to
//   cluster 2 / position 0 / no pending FAT reply.
// ---------------------------------------------------------------------------
// FAT32 file sector sequencer
// Walks one open file's data sectors along its FAT32 cluster chain, asking for
// the FAT entry at each cluster boundary and resuming once it is returned.
// ---------------------------------------------------------------------------
module fat32_file_sector_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   fss_req_if.sink                            req_bus,
   fss_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fss_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fss_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fss_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   // ---- configuration registers ----
   logic [fss_pkg::ADDR_W-1:0]     fat_start_ff;
   logic [fss_pkg::ADDR_W-1:0]     data_start_ff;
   logic [fss_pkg::CS_W-1:0]       clus_sect_ff;

   // ---- file walk state ----
   logic [fss_pkg::CLUSTER_W-1:0]  cur_cluster_ff, cur_cluster_in;
   logic [fss_pkg::INDEX_W-1:0]    sect_idx_ff, sect_idx_in;
   logic [fss_pkg::CLUSTER_W-1:0]  start_cluster_ff, start_cluster_in;
   logic [fss_pkg::POS_W-1:0]      byte_pos_ff, byte_pos_in;
   logic [fss_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic                           await_ff, await_in;

   // ---- result queue ----
   fss_pkg::fss_rsp_type           rq_ff [fss_pkg::RSP_DEPTH];
   logic [fss_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [fss_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [fss_pkg::RSP_CNT_W-1:0]  cnt_ff, cnt_in;

   // ---- per-request working signals ----
   logic                           req_xfer;
   logic                           rsp_xfer;
   logic                           csr_wr;
   fss_pkg::fss_op_type            op_code;
   fss_pkg::fss_rsp_type           res0, res1;
   logic                           two_res;
   logic [fss_pkg::CS_W-1:0]       cs_eff;
   logic [fss_pkg::ADDR_W-1:0]     clus_base;
   logic [fss_pkg::ADDR_W-1:0]     data_addr;
   logic [fss_pkg::POS_W-1:0]      pos_next;
   logic [fss_pkg::CLUSTER_W-1:0]  fat_bytes;
   logic [fss_pkg::ENTRY_W-1:0]    entry;
   logic [fss_pkg::RSP_CNT_W-1:0]  push_cnt;

   // Room for two results is kept free so any request can go in; the check
   // looks only at our own fill level, never at rsp ready.
   assign req_bus.ready = (cnt_ff <= fss_pkg::RSP_CNT_W'(fss_pkg::RSP_DEPTH - 2));
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rsp_xfer      = rsp_bus.valid && rsp_bus.ready;
   assign op_code       = fss_pkg::fss_op_type'(req_bus.op);

   // APB: zero-wait writes, combinational read-back
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         fss_pkg::REG_FAT_START:  csr_prdata = fat_start_ff;
         fss_pkg::REG_DATA_START: csr_prdata = data_start_ff;
         fss_pkg::REG_CLUS_SECT:  csr_prdata = fss_pkg::CSR_DATA_W'(clus_sect_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Data sector: (cluster - 2) * sectors/cluster + data start + index, mod 2^32.
   // One 32x8 multiply then the adds; all of it off the current state.
   assign cs_eff    = fss_pkg::eff_sectors(clus_sect_ff);
   assign clus_base = fss_pkg::ADDR_W'((cur_cluster_ff - fss_pkg::CLUSTER_W'(2)) *
                                       fss_pkg::CLUSTER_W'(cs_eff));
   assign data_addr = clus_base + data_start_ff + fss_pkg::ADDR_W'(sect_idx_ff);
   assign pos_next  = byte_pos_ff + fss_pkg::POS_W'(fss_pkg::SECTOR_BYTES);

   // FAT entry is 4 bytes per cluster; split byte address into sector and offset
   assign fat_bytes = {cur_cluster_ff[fss_pkg::CLUSTER_W-3:0], 2'b00};
   assign entry     = req_bus.cluster_value[fss_pkg::ENTRY_W-1:0];

   always_comb begin
      cur_cluster_in   = cur_cluster_ff;
      sect_idx_in      = sect_idx_ff;
      start_cluster_in = start_cluster_ff;
      byte_pos_in      = byte_pos_ff;
      size_in          = size_ff;
      await_in         = await_ff;

      res0             = '0;
      res0.kind        = fss_pkg::KIND_ACK;
      res0.last        = 1'b1;
      res1             = '0;
      res1.kind        = fss_pkg::KIND_FAT;
      res1.last        = 1'b1;
      two_res          = 1'b0;

      unique case (op_code)
         fss_pkg::OP_OPEN: begin
            start_cluster_in = fss_pkg::map_cluster(req_bus.cluster_value);
            cur_cluster_in   = fss_pkg::map_cluster(req_bus.cluster_value);
            size_in          = req_bus.file_bytes;
            byte_pos_in      = '0;
            sect_idx_in      = '0;
            await_in         = 1'b0;
         end
         fss_pkg::OP_REWIND: begin
            cur_cluster_in = start_cluster_ff;
            byte_pos_in    = '0;
            sect_idx_in    = '0;
            await_in       = 1'b0;
         end
         fss_pkg::OP_REPLY: begin
            // a reply nobody asked for is just acknowledged
            if (await_ff) begin
               await_in = 1'b0;
               if (entry == '1) begin
                  // end of chain: park position at size so reads give EOF
                  byte_pos_in = fss_pkg::POS_W'(size_ff);
                  res0.kind   = fss_pkg::KIND_CHAIN_END;
               end else begin
                  cur_cluster_in = fss_pkg::map_cluster(fss_pkg::CLUSTER_W'(entry));
                  sect_idx_in    = '0;
               end
            end
         end
         fss_pkg::OP_READ: begin
            if (await_ff) begin
               res0.kind = fss_pkg::KIND_BUSY;
            end else if (byte_pos_ff >= fss_pkg::POS_W'(size_ff)) begin
               res0.kind = fss_pkg::KIND_EOF;
            end else begin
               res0.kind        = fss_pkg::KIND_DATA;
               res0.sector_addr = data_addr;
               res0.valid_bytes = fss_pkg::VALID_W'(fss_pkg::SECTOR_BYTES);
               byte_pos_in      = pos_next;
               if (pos_next >= fss_pkg::POS_W'(size_ff)) begin
                  // tail sector: only size - position bytes are the file's
                  res0.valid_bytes = fss_pkg::VALID_W'(size_ff -
                                                       byte_pos_ff[fss_pkg::SIZE_W-1:0]);
               end else if ((fss_pkg::CS_W'(sect_idx_ff) + fss_pkg::CS_W'(1)) < cs_eff) begin
                  sect_idx_in = sect_idx_ff + fss_pkg::INDEX_W'(1);
               end else begin
                  // last sector of cluster: also ask for the chain entry
                  res0.last         = 1'b0;
                  res1.sector_addr  = fat_start_ff + (fat_bytes >> fss_pkg::SECTOR_SHIFT);
                  res1.entry_offset = fss_pkg::OFFSET_W'(fat_bytes[fss_pkg::SECTOR_SHIFT-1:0]);
                  two_res           = 1'b1;
                  await_in          = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // queue pointer and fill bookkeeping
   always_comb begin
      push_cnt  = '0;
      if (req_xfer) begin
         push_cnt = two_res ? fss_pkg::RSP_CNT_W'(2) : fss_pkg::RSP_CNT_W'(1);
      end
      wr_ptr_in = wr_ptr_ff + fss_pkg::RSP_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + fss_pkg::RSP_PTR_W'(rsp_xfer);
      cnt_in    = cnt_ff + push_cnt - fss_pkg::RSP_CNT_W'(rsp_xfer);
   end

   // control, configuration and file state
   always_ff @(posedge clock) begin
      if (reset) begin
         fat_start_ff     <= '0;
         data_start_ff    <= '0;
         clus_sect_ff     <= fss_pkg::CS_W'(1);
         cur_cluster_ff   <= fss_pkg::CLUSTER_W'(2);
         sect_idx_ff      <= '0;
         start_cluster_ff <= fss_pkg::CLUSTER_W'(2);
         byte_pos_ff      <= '0;
         size_ff          <= '0;
         await_ff         <= 1'b0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         cnt_ff           <= '0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[3:2])
               fss_pkg::REG_FAT_START:  fat_start_ff  <= csr_pwdata;
               fss_pkg::REG_DATA_START: data_start_ff <= csr_pwdata;
               fss_pkg::REG_CLUS_SECT:  clus_sect_ff  <= csr_pwdata[fss_pkg::CS_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_xfer) begin
            cur_cluster_ff   <= cur_cluster_in;
            sect_idx_ff      <= sect_idx_in;
            start_cluster_ff <= start_cluster_in;
            byte_pos_ff      <= byte_pos_in;
            size_ff          <= size_in;
            await_ff         <= await_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // result payload storage, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rq_ff[wr_ptr_ff] <= res0;
         if (two_res) begin
            rq_ff[wr_ptr_ff + fss_pkg::RSP_PTR_W'(1)] <= res1;
         end
      end
   end

   assign rsp_bus.valid        = (cnt_ff != '0);
   assign rsp_bus.kind         = rq_ff[rd_ptr_ff].kind;
   assign rsp_bus.sector_addr  = rq_ff[rd_ptr_ff].sector_addr;
   assign rsp_bus.entry_offset = rq_ff[rd_ptr_ff].entry_offset;
   assign rsp_bus.valid_bytes  = rq_ff[rd_ptr_ff].valid_bytes;
   assign rsp_bus.last         = rq_ff[rd_ptr_ff].last;

endmodule

/* rtl/core/fss_checker.sv */
// ---------------------------------------------------------------------------
// FAT32 sector sequencer port checker
// Watches the response channel for ordering and field rules; bound to the sequencer unit.
// ---------------------------------------------------------------------------
`include "fat32_file_sector_sequencer_unit_assert.svh"

module fss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [fss_pkg::KIND_W-1:0]     rsp_kind,
   input logic [fss_pkg::ADDR_W-1:0]     rsp_sector_addr,
   input logic [fss_pkg::OFFSET_W-1:0]   rsp_entry_offset,
   input logic [fss_pkg::VALID_W-1:0]    rsp_valid_bytes,
   input logic                           rsp_last
);

   logic [fss_pkg::KIND_W+fss_pkg::ADDR_W+fss_pkg::OFFSET_W+fss_pkg::VALID_W:0] rsp_payload;
   logic                           rsp_stall;
   logic                           rsp_is_data;
   logic                           rsp_is_fat;
   logic [fss_pkg::VALID_W-1:0]    full_sector;

   assign rsp_payload = {rsp_kind, rsp_sector_addr, rsp_entry_offset, rsp_valid_bytes,
                         rsp_last};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_is_data = rsp_valid && (rsp_kind == fss_pkg::KIND_DATA);
   assign rsp_is_fat  = rsp_valid && (rsp_kind == fss_pkg::KIND_FAT);
   assign full_sector = fss_pkg::VALID_W'(fss_pkg::SECTOR_BYTES);

   // stalled result holds
   `FSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // a FAT fetch always closes its request
   `FSS_ASSERT_IMP(a_fat_is_last, clock, reset, rsp_is_fat, rsp_last)

   // only data results carry a byte count
   `FSS_ASSERT_IMP(a_count_data_only, clock, reset, rsp_valid && !rsp_is_data, rsp_valid_bytes == '0)

   // a data sector followed by a FAT fetch is a full sector
   `FSS_ASSERT_IMP(a_full_before_fat, clock, reset, rsp_is_data && !rsp_last, rsp_valid_bytes == full_sector)

endmodule

bind fat32_file_sector_sequencer_unit fss_checker u_fss_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_sector_addr  (rsp_bus.sector_addr),
   .rsp_entry_offset (rsp_bus.entry_offset),
   .rsp_valid_bytes  (rsp_bus.valid_bytes),
   .rsp_last         (rsp_bus.last)
);

/* tb/sv/fss_walk_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FAT32 sector walk checker
// Watches the request, result and register ports of the sector sequencer,
// keeps its own copy of the file walk state and compares every result
// transfer against the oldest predicted result.
// ---------------------------------------------------------------------------
module fss_walk_checker
   import fss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fss_req_if                    req_mon,
   fss_rsp_if                    rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    error_count,
   output int                    outstanding
);

   localparam logic [CLUSTER_W-1:0] CHAIN_END_MARK = 32'h0FFF_FFFF;

   // register copies
   logic [ADDR_W-1:0]    fat_base;
   logic [ADDR_W-1:0]    data_base;
   logic [CS_W-1:0]      clus_sectors;

   // file walk state
   logic [CLUSTER_W-1:0] cur_cluster;
   logic [CLUSTER_W-1:0] first_cluster;
   logic [INDEX_W-1:0]   sect_idx;
   logic [POS_W-1:0]     bytes_issued;
   logic [SIZE_W-1:0]    file_size;
   logic                 entry_wait;

   fss_rsp_type          walk_rsp_q[$];
   fss_rsp_type          want;
   int                   fails;
   int                   shown;

   function automatic fss_rsp_type walk_rsp(input fss_kind_type kind,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [OFFSET_W-1:0] off,
                                            input logic [VALID_W-1:0] vb,
                                            input logic last);
      fss_rsp_type r;
      r.kind         = kind;
      r.sector_addr  = addr;
      r.entry_offset = off;
      r.valid_bytes  = vb;
      r.last         = last;
      return r;
   endfunction

   // advance the walk by one request and queue what it should produce
   task automatic predict_walk(input fss_op_type op, input logic [CLUSTER_W-1:0] cval,
                               input logic [SIZE_W-1:0] fbytes);
      logic [31:0]          cs;
      logic [ADDR_W-1:0]    addr;
      logic [31:0]          fat_bytes;
      logic [CLUSTER_W-1:0] next_entry;
      logic [POS_W-1:0]     pos_after;
      logic [VALID_W-1:0]   tail_bytes;
      case (op)
         OP_OPEN: begin
            first_cluster = (cval < 2) ? CLUSTER_W'(2) : cval;
            cur_cluster   = first_cluster;
            file_size     = fbytes;
            bytes_issued  = '0;
            sect_idx      = '0;
            entry_wait    = 1'b0;
            walk_rsp_q.push_back(walk_rsp(KIND_ACK, '0, '0, '0, 1'b1));
         end
         OP_REWIND: begin
            cur_cluster  = first_cluster;
            bytes_issued = '0;
            sect_idx     = '0;
            entry_wait   = 1'b0;
            walk_rsp_q.push_back(walk_rsp(KIND_ACK, '0, '0, '0, 1'b1));
         end
         OP_REPLY: begin
            if (!entry_wait) begin
               walk_rsp_q.push_back(walk_rsp(KIND_ACK, '0, '0, '0, 1'b1));
            end else begin
               entry_wait = 1'b0;
               next_entry = cval & CHAIN_END_MARK;
               if (next_entry == CHAIN_END_MARK) begin
                  // no further cluster: park the position at the end of the file
                  bytes_issued = {1'b0, file_size};
                  walk_rsp_q.push_back(walk_rsp(KIND_CHAIN_END, '0, '0, '0, 1'b1));
               end else begin
                  cur_cluster = (next_entry < 2) ? CLUSTER_W'(2) : next_entry;
                  sect_idx    = '0;
                  walk_rsp_q.push_back(walk_rsp(KIND_ACK, '0, '0, '0, 1'b1));
               end
            end
         end
         default: begin
            if (clus_sectors == 0)
               cs = 32'd1;
            else if (clus_sectors > CS_MAX)
               cs = 32'(CS_MAX);
            else
               cs = 32'(clus_sectors);
            if (entry_wait) begin
               walk_rsp_q.push_back(walk_rsp(KIND_BUSY, '0, '0, '0, 1'b1));
            end else if (bytes_issued >= {1'b0, file_size}) begin
               walk_rsp_q.push_back(walk_rsp(KIND_EOF, '0, '0, '0, 1'b1));
            end else begin
               addr         = (cur_cluster - 32'd2) * cs + data_base + 32'(sect_idx);
               pos_after    = bytes_issued + POS_W'(SECTOR_BYTES);
               bytes_issued = pos_after;
               if (pos_after >= {1'b0, file_size}) begin
                  // tail sector: only part of it belongs to the file
                  tail_bytes = VALID_W'(POS_W'(SECTOR_BYTES) - (pos_after - {1'b0, file_size}));
                  walk_rsp_q.push_back(walk_rsp(KIND_DATA, addr, '0, tail_bytes, 1'b1));
               end else if (32'(sect_idx) + 32'd1 < cs) begin
                  sect_idx = sect_idx + 1'b1;
                  walk_rsp_q.push_back(walk_rsp(KIND_DATA, addr, '0,
                                                VALID_W'(SECTOR_BYTES), 1'b1));
               end else begin
                  // cluster boundary: data sector, then the FAT entry to fetch
                  fat_bytes = cur_cluster << 2;
                  walk_rsp_q.push_back(walk_rsp(KIND_DATA, addr, '0,
                                                VALID_W'(SECTOR_BYTES), 1'b0));
                  walk_rsp_q.push_back(walk_rsp(KIND_FAT, fat_base + (fat_bytes >> SECTOR_SHIFT),
                                                fat_bytes[OFFSET_W-1:0], '0, 1'b1));
                  entry_wait = 1'b1;
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fat_base      = '0;
         data_base     = '0;
         clus_sectors  = CS_W'(1);
         cur_cluster   = CLUSTER_W'(2);
         first_cluster = CLUSTER_W'(2);
         sect_idx      = '0;
         bytes_issued  = '0;
         file_size     = '0;
         entry_wait    = 1'b0;
         walk_rsp_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_FAT_START:  fat_base     = csr_pwdata;
               REG_DATA_START: data_base    = csr_pwdata;
               REG_CLUS_SECT:  clus_sectors = csr_pwdata[CS_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_walk(fss_op_type'(req_mon.op), req_mon.cluster_value, req_mon.file_bytes);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (walk_rsp_q.size() == 0) begin
               fails++;
               if (shown < 10) begin
                  shown++;
                  $display("[%0t] result transfer with nothing predicted: kind=%0d addr=%h",
                           $time, rsp_mon.kind, rsp_mon.sector_addr);
               end
            end else begin
               want = walk_rsp_q.pop_front();
               if (rsp_mon.kind !== want.kind || rsp_mon.sector_addr !== want.sector_addr ||
                   rsp_mon.entry_offset !== want.entry_offset ||
                   rsp_mon.valid_bytes !== want.valid_bytes || rsp_mon.last !== want.last) begin
                  fails++;
                  if (shown < 10) begin
                     shown++;
                     $display("[%0t] result mismatch: exp kind=%0d addr=%h off=%0d valid=%0d last=%0d",
                              $time, want.kind, want.sector_addr, want.entry_offset,
                              want.valid_bytes, want.last);
                     $display("                  got kind=%0d addr=%h off=%0d valid=%0d last=%0d",
                              rsp_mon.kind, rsp_mon.sector_addr, rsp_mon.entry_offset,
                              rsp_mon.valid_bytes, rsp_mon.last);
                  end
               end
            end
         end
      end
      outstanding <= walk_rsp_q.size();
      error_count <= fails;
   end

   initial begin
      fails       = 0;
      shown       = 0;
      outstanding = 0;
      error_count = 0;
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FAT32 sector sequencer testbench
// Drives open, read, FAT reply and rewind requests through the sequencer,
// first a directed set of corner cases, then random file walks over several
// register settings, random idling on both channels but for the first walk set.
// The checker beside the block predicts and compares every result transfer.
// ---------------------------------------------------------------------------
module tb_top;
   import fss_pkg::*;

   // generous bound for a few hundred requests
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    error_count;
   int                    outstanding;
   int                    cycle_count = 0;
   int                    items_sent  = 0;
   int                    rsp_hold;
   int                    hold_draw;
   bit                    no_idling;   // when set, neither side inserts gaps or stalls
   int                    walk_cs;     // effective sectors per cluster, for planning walks

   fss_req_if req_bus ();
   fss_rsp_if rsp_bus ();

   fat32_file_sector_sequencer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fss_walk_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: after each transfer draw a random stall with ready low, unless idling is off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         hold_draw      = no_idling ? 0 : $urandom_range(0, 6);
         rsp_hold      <= hold_draw;
         rsp_bus.ready <= (hold_draw == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= (rsp_hold == 1);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Drop valid and hold off until every predicted result has been taken.
   // The first edge lets the checker's count catch up with the last transfer.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Register write, only with the block idle: setup phase, then access phase.
   task automatic csr_write(input logic [1:0] reg_sel, input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == REG_CLUS_SECT)
         walk_cs = (value[CS_W-1:0] == 0) ? 1 : (value[CS_W-1:0] > CS_MAX) ? CS_MAX :
                   int'(value[CS_W-1:0]);
   endtask

   // One request transfer. Valid is left high on return so that a back-to-back
   // request never lowers and raises it within the same step.
   task automatic send_item(input fss_op_type op, input logic [CLUSTER_W-1:0] cval,
                            input logic [SIZE_W-1:0] fbytes);
      int gap;
      gap = no_idling ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.op            <= op;
      req_bus.cluster_value <= cval;
      req_bus.file_bytes    <= fbytes;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // FAT entry as it might come back from disc: random top nibble, mostly a
   // plausible next cluster, sometimes a reserved cluster, a random value or the chain end.
   function automatic logic [CLUSTER_W-1:0] fat_entry();
      logic [3:0]  top;
      logic [27:0] low;
      int          pick;
      top  = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 11);
      if (pick == 0)
         low = 28'hFFF_FFFF;
      else if (pick == 1)
         low = 28'($urandom_range(0, 1));
      else if (pick == 2)
         low = 28'($urandom);
      else
         low = 28'($urandom_range(2, 5000));
      return {top, low};
   endfunction

   // Random file walks: mostly an open followed by the reads of the whole file,
   // with the FAT reply at each cluster boundary; the rest is noise.
   task automatic walk_files(input int budget);
      int                   base;
      int                   n_sectors;
      int                   rd;
      logic [SIZE_W-1:0]    fsize;
      logic [CLUSTER_W-1:0] entry;
      logic [CLUSTER_W-1:0] start;
      base = items_sent;
      while (items_sent - base < budget) begin
         if ($urandom_range(0, 7) == 0) begin
            send_item(fss_op_type'($urandom_range(0, 3)), $urandom, $urandom);
         end else begin
            // file length: usually a few sectors, sometimes a cluster or just over
            if ($urandom_range(0, (walk_cs > 16) ? 7 : 2) == 0)
               n_sectors = walk_cs + $urandom_range(0, 2);
            else
               n_sectors = $urandom_range(0, (walk_cs < 4) ? 3 * walk_cs + 1 : 7);
            if (n_sectors == 0)
               fsize = '0;
            else
               fsize = SIZE_W'(n_sectors * SECTOR_BYTES) -
                       ($urandom_range(0, 1) ? SIZE_W'($urandom_range(0, 511)) : '0);
            case ($urandom_range(0, 3))
               0:       start = $urandom_range(0, 1);
               1:       start = $urandom;
               default: start = $urandom_range(2, 4000);
            endcase
            send_item(OP_OPEN, start, fsize);
            for (rd = 0; rd < n_sectors; rd++) begin
               if ($urandom_range(0, 29) == 0) drain_results();
               send_item(OP_READ, $urandom, $urandom);
               if ((rd + 1) % walk_cs == 0 && rd != n_sectors - 1) begin
                  if ($urandom_range(0, 9) == 0) send_item(OP_READ, $urandom, $urandom);
                  entry = fat_entry();
                  send_item(OP_REPLY, entry, $urandom);
                  if (entry[27:0] == 28'hFFF_FFFF) break;
               end
            end
            // sometimes a read beyond the end, now and again a rewind and a re-read
            if ($urandom_range(0, 1) == 0) send_item(OP_READ, $urandom, $urandom);
            if ($urandom_range(0, 3) == 0) begin
               send_item(OP_REWIND, $urandom, $urandom);
               send_item(OP_READ, $urandom, $urandom);
            end
         end
      end
   endtask

   initial begin
      no_idling             = 1'b0;
      walk_cs               = 1;
      reset                 <= 1'b1;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.op            <= OP_OPEN;
      req_bus.cluster_value <= '0;
      req_bus.file_bytes    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed corner cases ---
      send_item(OP_READ, '0, '0);                         // empty file out of reset: end of file
      send_item(OP_REPLY, 32'h0000_1234, '0);             // reply with nothing awaited: ack
      send_item(OP_REWIND, '0, '0);

      csr_write(REG_FAT_START, 32'h0000_0100);
      csr_write(REG_DATA_START, 32'h0000_1000);
      csr_write(REG_CLUS_SECT, 32'd2);

      send_item(OP_OPEN, 32'd0, 32'd1300);                // cluster 0 taken as 2
      send_item(OP_READ, '0, '0);
      send_item(OP_READ, '0, '0);                         // cluster end: data plus FAT fetch
      send_item(OP_READ, '0, '0);                         // busy while the entry is awaited
      send_item(OP_REWIND, '0, '0);                       // drops the wait
      send_item(OP_READ, '0, '0);
      send_item(OP_READ, '0, '0);
      send_item(OP_REPLY, 32'hF000_0005, '0);             // top nibble masked off
      send_item(OP_READ, '0, '0);                         // shortened tail sector
      send_item(OP_READ, '0, '0);                         // past the end
      send_item(OP_REWIND, '0, '0);
      send_item(OP_READ, '0, '0);
      send_item(OP_READ, '0, '0);
      send_item(OP_REPLY, 32'hFFFF_FFFF, '0);             // end-of-chain marker
      send_item(OP_READ, '0, '0);
      send_item(OP_OPEN, 32'd1, 32'd512);                 // cluster 1 taken as 2, one full sector
      send_item(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_OPEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // largest cluster and size
      send_item(OP_READ, '0, '0);                         // sector number wraps
      send_item(OP_READ, '0, '0);                         // FAT byte offset wraps
      send_item(OP_REPLY, 32'h0000_0000, '0);
      send_item(OP_READ, '0, '0);

      // --- random walks over several register settings ---
      csr_write(REG_FAT_START, $urandom);
      csr_write(REG_DATA_START, $urandom);
      csr_write(REG_CLUS_SECT, 32'd4);
      no_idling = 1'b1;
      walk_files(80);
      no_idling = 1'b0;

      csr_write(REG_FAT_START, 32'hFFFF_FFFF);
      csr_write(REG_DATA_START, 32'hFFFF_FFFF);
      csr_write(REG_CLUS_SECT, 32'd1);
      walk_files(80);

      csr_write(REG_FAT_START, 32'd0);
      csr_write(REG_DATA_START, 32'd0);
      csr_write(REG_CLUS_SECT, 32'd128);
      walk_files(60);

      csr_write(REG_CLUS_SECT, 32'd0);                    // acts as one sector
      walk_files(40);

      csr_write(REG_CLUS_SECT, 32'hFFFF_FFFF);            // above 128, clamped
      walk_files(40);

      csr_write(REG_FAT_START, $urandom);
      csr_write(REG_DATA_START, $urandom);
      csr_write(REG_CLUS_SECT, $urandom_range(2, 9));
      walk_files(80);

      // --- wind down: let everything drain, then a short settle ---
      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
